@@ hw/rtl/sbc_pkg.sv @@
// Shared types and constants for the sprite blit clipper.
`timescale 1ns / 1ps
package sbc_pkg;

  // fixed-point constants
  localparam logic [15:0] ONE_Q12     = 16'd4096;
  localparam logic [27:0] HALF_Q8     = 28'd128;
  localparam logic [29:0] QUARTER_Q8  = 30'd64;
  localparam logic [43:0] HALF_Q16    = 44'd32768;
  localparam logic [32:0] ROUND_Q12   = 33'd8;

  // internal widths
  localparam int POS_W  = 30;   // screen position, signed Q.8
  localparam int SIZE_W = 28;   // screen size, Q.8
  localparam int SRP_W  = 31;   // source position, Q.16 texels
  localparam int EDGE_W = 24;   // clip edge, Q.8

  // divider geometry
  localparam int DIV_QW  = 28;
  localparam int DIV_NW  = 2 * DIV_QW;
  localparam int DIV_BPS = 2;
  localparam int DIV_NS  = DIV_QW / DIV_BPS;

  // stages in one axis clipper
  localparam int AX_LAT = 6 + 2 * DIV_NS;

  // register map
  localparam int ADDR_W = 5;
  typedef enum logic [2:0] {
    REG_CLIP_LEFT    = 3'd0,
    REG_CLIP_TOP     = 3'd1,
    REG_CLIP_WIDTH   = 3'd2,
    REG_CLIP_HEIGHT  = 3'd3,
    REG_RENDER_SCALE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [13:0] clip_left;
    logic [13:0] clip_top;
    logic [13:0] clip_width;
    logic [13:0] clip_height;
    logic [15:0] render_scale;
  } cfg_t;

  // one axis of a command while it is clipped
  typedef struct packed {
    logic signed [POS_W-1:0] p;
    logic [SIZE_W-1:0]       size;
    logic [SRP_W-1:0]        srp;
    logic [DIV_QW-1:0]       srs;
    logic [SIZE_W-1:0]       cut_amt;
    logic                    cut;
    logic                    act;
    logic                    mir;
  } ax_sb_t;

  localparam int AX_SB_W = $bits(ax_sb_t);

  // per-command flags that bypass the axis clippers
  typedef struct packed {
    logic clip_on;
    logic rej;
    logic mir;
  } side_t;

endpackage

@@ hw/rtl/sbc_in_if.sv @@
// Command channel interface of the sprite blit clipper.
`timescale 1ns / 1ps
interface sbc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [13:0]        src_off_x;
  logic [13:0]        src_off_y;
  logic [11:0]        src_size_w;
  logic [11:0]        src_size_h;
  logic [15:0]        scale_x;
  logic [15:0]        scale_y;
  logic               mirrored;

  modport source (
    output valid, pos_x, pos_y, src_off_x, src_off_y, src_size_w, src_size_h,
           scale_x, scale_y, mirrored,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, src_off_x, src_off_y, src_size_w, src_size_h,
           scale_x, scale_y, mirrored,
    output ready
  );
endinterface

@@ hw/rtl/sbc_out_if.sv @@
// Result channel interface of the sprite blit clipper.
`timescale 1ns / 1ps
interface sbc_out_if;
  logic               valid;
  logic               ready;
  logic               drawn;
  logic signed [31:0] dst_x;
  logic signed [31:0] dst_y;
  logic [30:0]        dst_w;
  logic [30:0]        dst_h;
  logic [14:0]        out_src_x;
  logic [14:0]        out_src_y;
  logic [11:0]        out_src_w;
  logic [11:0]        out_src_h;
  logic               flip;

  modport source (
    output valid, drawn, dst_x, dst_y, dst_w, dst_h, out_src_x, out_src_y,
           out_src_w, out_src_h, flip,
    input  ready
  );
  modport sink (
    input  valid, drawn, dst_x, dst_y, dst_w, dst_h, out_src_x, out_src_y,
           out_src_w, out_src_h, flip,
    output ready
  );
endinterface

@@ hw/rtl/sbc_div.sv @@
// Pipelined restoring divider, two quotient bits per stage, with sideband.
`timescale 1ns / 1ps
module sbc_div #(
  parameter int SB_W = 8
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [sbc_pkg::DIV_NW-1:0]  num,
  input  logic [sbc_pkg::DIV_QW-1:0]  den,
  input  logic [SB_W-1:0]             sb_in,
  output logic [sbc_pkg::DIV_QW-1:0]  quo,
  output logic [SB_W-1:0]             sb_out
);

  localparam int QW  = sbc_pkg::DIV_QW;
  localparam int RW  = QW + 1;
  localparam int NS  = sbc_pkg::DIV_NS;
  localparam int BPS = sbc_pkg::DIV_BPS;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QW-1:0] low;
    logic [QW-1:0] quo;
  } dst_t;

  dst_t            st_r  [NS];
  dst_t            st_nxt[NS];
  logic [QW-1:0]   den_r [NS];
  logic [SB_W-1:0] sb_r  [NS];

  function automatic dst_t div_step(input dst_t s, input logic [QW-1:0] d);
    dst_t          o;
    logic [RW-1:0] t;
    o = s;
    for (int b = 0; b < BPS; b++) begin
      t     = {o.rem[RW-2:0], o.low[QW-1]};
      o.low = {o.low[QW-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        o.rem = t - {1'b0, d};
        o.quo = {o.quo[QW-2:0], 1'b1};
      end else begin
        o.rem = t;
        o.quo = {o.quo[QW-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  // quotient fits QW bits, so the top half of the numerator starts the remainder
  always_comb begin
    dst_t s0;
    s0.rem    = {1'b0, num[2*QW-1:QW]};
    s0.low    = num[QW-1:0];
    s0.quo    = '0;
    st_nxt[0] = div_step(s0, den);
    for (int k = 1; k < NS; k++) begin
      st_nxt[k] = div_step(st_r[k-1], den_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]  <= st_nxt[0];
      den_r[0] <= den;
      sb_r[0]  <= sb_in;
      for (int k = 1; k < NS; k++) begin
        st_r[k]  <= st_nxt[k];
        den_r[k] <= den_r[k-1];
        sb_r[k]  <= sb_r[k-1];
      end
    end
  end

  assign quo    = st_r[NS-1].quo;
  assign sb_out = sb_r[NS-1];

endmodule

@@ hw/rtl/sbc_axis.sv @@
// One-axis edge clipper: near edge cut, then far edge cut, source scaled by division.
`timescale 1ns / 1ps
module sbc_axis (
  input  logic                          clk,
  input  logic                          en,
  input  logic [sbc_pkg::EDGE_W-1:0]    lo,
  input  logic [sbc_pkg::EDGE_W-1:0]    hi,
  input  sbc_pkg::ax_sb_t               ax_in,
  output sbc_pkg::ax_sb_t               ax_out
);

  localparam int QW = sbc_pkg::DIV_QW;

  sbc_pkg::ax_sb_t c0_nxt, c0_r, sb1_r, sbq1, u1_nxt, u1_r;
  sbc_pkg::ax_sb_t r0_nxt, r0_r, sb2_r, sbq2, u2_nxt, u2_r;
  logic [sbc_pkg::DIV_NW-1:0] n1_r, n2_r;
  logic [QW-1:0]              d1_r, d2_r, q1, q2;
  logic [QW-1:0]              qa, qb;
  logic signed [31:0]         pe, loe, hie, far_e;

  assign loe = $signed({8'b0, lo});
  assign hie = $signed({8'b0, hi});

  // near edge cut amount
  always_comb begin
    pe             = 32'(ax_in.p);
    c0_nxt         = ax_in;
    c0_nxt.cut     = ax_in.act && (pe < loe);
    c0_nxt.cut_amt = c0_nxt.cut ? sbc_pkg::SIZE_W'(loe - pe) : '0;
  end

  sbc_div #(.SB_W(sbc_pkg::AX_SB_W)) u_div_near (
    .clk(clk), .en(en), .num(n1_r), .den(d1_r), .sb_in(sb1_r),
    .quo(q1), .sb_out(sbq1)
  );

  // apply near cut; a mirrored sprite keeps its source start
  always_comb begin
    qa          = sbq1.cut ? q1 : '0;
    u1_nxt      = sbq1;
    u1_nxt.srs  = sbq1.srs - qa;
    u1_nxt.srp  = sbq1.srp + (sbq1.mir ? '0 : sbc_pkg::SRP_W'(qa));
    u1_nxt.p    = sbq1.cut ? sbc_pkg::POS_W'(loe) : sbq1.p;
    u1_nxt.size = sbq1.size - sbq1.cut_amt;
  end

  // far edge cut amount
  always_comb begin
    far_e          = 32'(u1_r.p) + $signed({4'b0, u1_r.size});
    r0_nxt         = u1_r;
    r0_nxt.cut     = u1_r.act && (u1_r.size != '0) && (far_e > hie);
    r0_nxt.cut_amt = r0_nxt.cut ? sbc_pkg::SIZE_W'(far_e - hie) : '0;
  end

  sbc_div #(.SB_W(sbc_pkg::AX_SB_W)) u_div_far (
    .clk(clk), .en(en), .num(n2_r), .den(d2_r), .sb_in(sb2_r),
    .quo(q2), .sb_out(sbq2)
  );

  // apply far cut; a mirrored sprite shifts its source start here
  always_comb begin
    qb          = sbq2.cut ? q2 : '0;
    u2_nxt      = sbq2;
    u2_nxt.srs  = sbq2.srs - qb;
    u2_nxt.srp  = sbq2.srp + (sbq2.mir ? sbc_pkg::SRP_W'(qb) : '0);
    u2_nxt.size = sbq2.size - sbq2.cut_amt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0_r  <= c0_nxt;
      n1_r  <= sbc_pkg::DIV_NW'(c0_r.cut_amt) * sbc_pkg::DIV_NW'(c0_r.srs);
      d1_r  <= c0_r.size;
      sb1_r <= c0_r;
      u1_r  <= u1_nxt;
      r0_r  <= r0_nxt;
      n2_r  <= sbc_pkg::DIV_NW'(r0_r.cut_amt) * sbc_pkg::DIV_NW'(r0_r.srs);
      d2_r  <= r0_r.size;
      sb2_r <= r0_r;
      u2_r  <= u2_nxt;
    end
  end

  assign ax_out = u2_r;

endmodule

@@ hw/rtl/sbc_regs.sv @@
// APB-style configuration registers of the sprite blit clipper.
`timescale 1ns / 1ps
module sbc_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sbc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output sbc_pkg::cfg_t               cfg
);

  sbc_pkg::cfg_t    cfg_r;
  sbc_pkg::reg_idx_t idx;
  logic             wr;

  assign idx    = sbc_pkg::reg_idx_t'(paddr[sbc_pkg::ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r              <= '0;
      cfg_r.render_scale <= sbc_pkg::ONE_Q12;
    end else if (wr) begin
      unique case (idx)
        sbc_pkg::REG_CLIP_LEFT:    cfg_r.clip_left    <= pwdata[13:0];
        sbc_pkg::REG_CLIP_TOP:     cfg_r.clip_top     <= pwdata[13:0];
        sbc_pkg::REG_CLIP_WIDTH:   cfg_r.clip_width   <= pwdata[13:0];
        sbc_pkg::REG_CLIP_HEIGHT:  cfg_r.clip_height  <= pwdata[13:0];
        sbc_pkg::REG_RENDER_SCALE: cfg_r.render_scale <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sbc_pkg::REG_CLIP_LEFT:    prdata = {18'b0, cfg_r.clip_left};
      sbc_pkg::REG_CLIP_TOP:     prdata = {18'b0, cfg_r.clip_top};
      sbc_pkg::REG_CLIP_WIDTH:   prdata = {18'b0, cfg_r.clip_width};
      sbc_pkg::REG_CLIP_HEIGHT:  prdata = {18'b0, cfg_r.clip_height};
      sbc_pkg::REG_RENDER_SCALE: prdata = {16'b0, cfg_r.render_scale};
      default:                   prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/sprite_blit_clipper.sv @@
// Sprite blit clipper: scales a sprite draw command to screen space, clips it to the
// clip rectangle and shrinks the source region in proportion. It takes one command
// per cycle unless the result stalls and returns one result per command in order.
// The pipeline is 39 register stages deep, set mostly by the two chained 28-bit
// dividers of each axis (near edge, then far edge), each 14 stages as they resolve
// two quotient bits per stage. A stalled result stalls the whole pipeline in place.
// The scale register is read live by stage 1, the clip registers by stage 4 and the
// axis clippers, so write them only while the block is empty.
`timescale 1ns / 1ps
module sprite_blit_clipper (
  input  logic                        clk,
  input  logic                        rst_n,
  sbc_in_if.sink                      in_cmd,
  sbc_out_if.source                   out_res,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [sbc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  localparam int AXL = sbc_pkg::AX_LAT;
  localparam int LAT = 5 + AXL;

  sbc_pkg::cfg_t cfg;
  logic          adv;
  logic          vld_r [LAT];

  sbc_regs u_regs (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .pready(cfg_pready), .cfg(cfg)
  );

  assign adv          = !vld_r[LAT-1] || out_res.ready;
  assign in_cmd.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_cmd.valid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // stage 1: products
  logic signed [32:0] pxg_r, pyg_r;
  logic [27:0]        swsx_r, shsy_r;
  logic [15:0]        g1_r;
  logic               ins1_r, ins2_r;
  logic [13:0]        offx1_r, offy1_r, offx2_r, offy2_r, offx3_r, offy3_r;
  logic [11:0]        sw1_r, sh1_r, sw2_r, sh2_r, sw3_r, sh3_r;
  logic               mir1_r, mir2_r, mir3_r;

  // stage 2: rounded position, full size product
  logic signed [32:0]         xs, ys;
  logic signed [29:0]         x2_r, y2_r, x3_r, y3_r;
  logic [43:0]                wprod_r, hprod_r, wrnd, hrnd;
  logic [sbc_pkg::SIZE_W-1:0] w3_r, h3_r;

  assign xs   = (pxg_r + $signed(sbc_pkg::ROUND_Q12)) >>> 4;
  assign ys   = (pyg_r + $signed(sbc_pkg::ROUND_Q12)) >>> 4;
  assign wrnd = (wprod_r + sbc_pkg::HALF_Q16) >> 16;
  assign hrnd = (hprod_r + sbc_pkg::HALF_Q16) >> 16;

  always_ff @(posedge clk) begin
    if (adv) begin
      pxg_r   <= $signed(in_cmd.pos_x) * $signed({1'b0, cfg.render_scale});
      pyg_r   <= $signed(in_cmd.pos_y) * $signed({1'b0, cfg.render_scale});
      swsx_r  <= 28'(in_cmd.src_size_w) * 28'(in_cmd.scale_x);
      shsy_r  <= 28'(in_cmd.src_size_h) * 28'(in_cmd.scale_y);
      g1_r    <= cfg.render_scale;
      ins1_r  <= cfg.render_scale < sbc_pkg::ONE_Q12;
      offx1_r <= in_cmd.src_off_x;
      offy1_r <= in_cmd.src_off_y;
      sw1_r   <= in_cmd.src_size_w;
      sh1_r   <= in_cmd.src_size_h;
      mir1_r  <= in_cmd.mirrored;

      x2_r    <= $signed(xs[29:0]) - (ins1_r ? $signed(sbc_pkg::QUARTER_Q8) : 30'sd0);
      y2_r    <= $signed(ys[29:0]) - (ins1_r ? $signed(sbc_pkg::QUARTER_Q8) : 30'sd0);
      wprod_r <= 44'(swsx_r) * 44'(g1_r);
      hprod_r <= 44'(shsy_r) * 44'(g1_r);
      ins2_r  <= ins1_r;
      offx2_r <= offx1_r;
      offy2_r <= offy1_r;
      sw2_r   <= sw1_r;
      sh2_r   <= sh1_r;
      mir2_r  <= mir1_r;

      x3_r    <= x2_r;
      y3_r    <= y2_r;
      w3_r    <= wrnd[27:0] + (ins2_r ? sbc_pkg::HALF_Q8 : '0);
      h3_r    <= hrnd[27:0] + (ins2_r ? sbc_pkg::HALF_Q8 : '0);
      offx3_r <= offx2_r;
      offy3_r <= offy2_r;
      sw3_r   <= sw2_r;
      sh3_r   <= sh2_r;
      mir3_r  <= mir2_r;
    end
  end

  // stage 4: clip rectangle test
  logic [sbc_pkg::EDGE_W-1:0] cl, ct, cr, cb;
  logic [14:0]                rsum, bsum;
  logic signed [31:0]         xe, ye, we, he;
  logic                       clip_on, rej;
  sbc_pkg::ax_sb_t            axx_r, axy_r, axx_o, axy_o;
  sbc_pkg::side_t             dly_r [AXL+1];

  assign rsum    = {1'b0, cfg.clip_left} + {1'b0, cfg.clip_width};
  assign bsum    = {1'b0, cfg.clip_top} + {1'b0, cfg.clip_height};
  assign cl      = {2'b0, cfg.clip_left, 8'b0};
  assign ct      = {2'b0, cfg.clip_top, 8'b0};
  assign cr      = {1'b0, rsum, 8'b0};
  assign cb      = {1'b0, bsum, 8'b0};
  assign xe      = 32'(x3_r);
  assign ye      = 32'(y3_r);
  assign we      = $signed({4'b0, w3_r});
  assign he      = $signed({4'b0, h3_r});
  assign clip_on = (cfg.clip_width != '0) && (cfg.clip_height != '0);
  assign rej     = (xe + we <= $signed({8'b0, cl})) || (xe >= $signed({8'b0, cr})) ||
                   (ye + he <= $signed({8'b0, ct})) || (ye >= $signed({8'b0, cb})) ||
                   (w3_r == '0) || (h3_r == '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      axx_r.p       <= x3_r;
      axx_r.size    <= w3_r;
      axx_r.srp     <= {1'b0, offx3_r, 16'b0};
      axx_r.srs     <= {sw3_r, 16'b0};
      axx_r.cut_amt <= '0;
      axx_r.cut     <= 1'b0;
      axx_r.act     <= clip_on && !rej;
      axx_r.mir     <= mir3_r;
      axy_r.p       <= y3_r;
      axy_r.size    <= h3_r;
      axy_r.srp     <= {1'b0, offy3_r, 16'b0};
      axy_r.srs     <= {sh3_r, 16'b0};
      axy_r.cut_amt <= '0;
      axy_r.cut     <= 1'b0;
      axy_r.act     <= clip_on && !rej;
      axy_r.mir     <= 1'b0;
      dly_r[0]      <= '{clip_on: clip_on, rej: rej, mir: mir3_r};
      for (int i = 1; i <= AXL; i++) dly_r[i] <= dly_r[i-1];
    end
  end

  sbc_axis u_axis_x (
    .clk(clk), .en(adv), .lo(cl), .hi(cr), .ax_in(axx_r), .ax_out(axx_o)
  );
  sbc_axis u_axis_y (
    .clk(clk), .en(adv), .lo(ct), .hi(cb), .ax_in(axy_r), .ax_out(axy_o)
  );

  // last stage: round the source, drop degenerate draws
  logic [sbc_pkg::SRP_W:0] oxr, oyr;
  logic [28:0]             owr, ohr;
  logic                    deg, drawn;
  sbc_pkg::side_t          sd;

  assign sd    = dly_r[AXL];
  assign oxr   = ({1'b0, axx_o.srp} + 32'd32768) >> 16;
  assign oyr   = ({1'b0, axy_o.srp} + 32'd32768) >> 16;
  assign owr   = ({1'b0, axx_o.srs} + 29'd32768) >> 16;
  assign ohr   = ({1'b0, axy_o.srs} + 29'd32768) >> 16;
  assign deg   = (owr == '0) || (ohr == '0) ||
                 (axx_o.size < sbc_pkg::HALF_Q8) || (axy_o.size < sbc_pkg::HALF_Q8);
  assign drawn = !(sd.clip_on && (sd.rej || deg));

  logic               drawn_r, flip_r;
  logic signed [31:0] dx_r, dy_r;
  logic [30:0]        dw_r, dh_r;
  logic [14:0]        sx_r, sy_r;
  logic [11:0]        sw_r, sh_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      drawn_r <= drawn;
      dx_r    <= drawn ? 32'(axx_o.p) : '0;
      dy_r    <= drawn ? 32'(axy_o.p) : '0;
      dw_r    <= drawn ? 31'(axx_o.size) : '0;
      dh_r    <= drawn ? 31'(axy_o.size) : '0;
      sx_r    <= drawn ? oxr[14:0] : '0;
      sy_r    <= drawn ? oyr[14:0] : '0;
      sw_r    <= drawn ? owr[11:0] : '0;
      sh_r    <= drawn ? ohr[11:0] : '0;
      flip_r  <= drawn && sd.mir;
    end
  end

  assign out_res.valid     = vld_r[LAT-1];
  assign out_res.drawn     = drawn_r;
  assign out_res.dst_x     = dx_r;
  assign out_res.dst_y     = dy_r;
  assign out_res.dst_w     = dw_r;
  assign out_res.dst_h     = dh_r;
  assign out_res.out_src_x = sx_r;
  assign out_res.out_src_y = sy_r;
  assign out_res.out_src_w = sw_r;
  assign out_res.out_src_h = sh_r;
  assign out_res.flip      = flip_r;

`ifndef SYNTHESIS
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.drawn) |-> (out_res.dst_x == '0 && out_res.dst_y == '0 &&
      out_res.dst_w == '0 && out_res.dst_h == '0 && out_res.out_src_w == '0 &&
      out_res.out_src_h == '0 && !out_res.flip))
    else $error("rejected draw carries non-zero fields");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.ready) |-> !in_cmd.ready)
    else $error("command taken while the result register is blocked");

  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (in_cmd.valid && in_cmd.ready) |=> vld_r[0])
    else $error("accepted command lost at pipeline entry");
`endif

endmodule

@@ bench/tb_sprite_blit_clipper.sv @@
// Self-checking testbench for the sprite blit clipper: random and edge-case commands.
`timescale 1ns / 1ps
module tb_sprite_blit_clipper;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [13:0]        src_off_x;
    logic [13:0]        src_off_y;
    logic [11:0]        src_size_w;
    logic [11:0]        src_size_h;
    logic [15:0]        scale_x;
    logic [15:0]        scale_y;
    logic               mirrored;
  } cmd_t;

  typedef struct packed {
    logic               drawn;
    logic signed [31:0] dst_x;
    logic signed [31:0] dst_y;
    logic [30:0]        dst_w;
    logic [30:0]        dst_h;
    logic [14:0]        src_x;
    logic [14:0]        src_y;
    logic [11:0]        src_w;
    logic [11:0]        src_h;
    logic               flip;
  } blit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [sbc_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  sbc_in_if  cmd_ch ();
  sbc_out_if res_ch ();

  sprite_blit_clipper dut (
    .clk(clk), .rst_n(rst_n), .in_cmd(cmd_ch.sink), .out_res(res_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // local copy of the register file
  logic [13:0] m_left = '0, m_top = '0, m_cw = '0, m_ch = '0;
  logic [15:0] m_scale = 16'd4096;

  cmd_t  cmd_q[$];
  blit_t blit_q[$];
  int    send_idle = 0, recv_idle = 0;
  bit    hold_send = 1'b0;
  int    errors = 0;
  int    quiet = 0;

  function automatic longint floor_sh4(longint v);
    return v >>> 4;
  endfunction

  function automatic longint rnd16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic blit_t clip_blit(cmd_t c);
    blit_t r;
    longint g, x, y, w, h, srx, sry, srw, srh, ox, oy, ow, oh;
    longint cl, ct, cr, cb, cut, cs;
    bit ok;
    g = m_scale;
    ok = 1;
    srx = longint'(c.src_off_x) << 16;  sry = longint'(c.src_off_y) << 16;
    srw = longint'(c.src_size_w) << 16; srh = longint'(c.src_size_h) << 16;
    ox = c.src_off_x; oy = c.src_off_y; ow = c.src_size_w; oh = c.src_size_h;
    x = floor_sh4(longint'(c.pos_x) * g + 8);
    y = floor_sh4(longint'(c.pos_y) * g + 8);
    w = (longint'(c.src_size_w) * c.scale_x * g + 32768) >>> 16;
    h = (longint'(c.src_size_h) * c.scale_y * g + 32768) >>> 16;
    if (g < 4096) begin
      x -= 64; y -= 64; w += 128; h += 128;
    end
    if (m_cw > 0 && m_ch > 0) begin
      cl = longint'(m_left) << 8;
      ct = longint'(m_top) << 8;
      cr = (longint'(m_left) + m_cw) << 8;
      cb = (longint'(m_top) + m_ch) << 8;
      if (x + w <= cl || x >= cr || y + h <= ct || y >= cb || w <= 0 || h <= 0) begin
        ok = 0;
      end else begin
        if (x < cl) begin
          cut = cl - x; cs = (cut * srw) / w;
          if (!c.mirrored) srx += cs;
          srw -= cs; x = cl; w -= cut;
        end
        if (w > 0 && x + w > cr) begin
          cut = x + w - cr; cs = (cut * srw) / w;
          if (c.mirrored) srx += cs;
          srw -= cs; w -= cut;
        end
        if (h > 0 && y < ct) begin
          cut = ct - y; cs = (cut * srh) / h;
          sry += cs; srh -= cs; y = ct; h -= cut;
        end
        if (h > 0 && y + h > cb) begin
          cut = y + h - cb; cs = (cut * srh) / h;
          srh -= cs; h -= cut;
        end
        ox = rnd16(srx); oy = rnd16(sry); ow = rnd16(srw); oh = rnd16(srh);
        if (ow <= 0 || oh <= 0 || w < 128 || h < 128) ok = 0;
      end
    end
    r = '0;
    if (ok) begin
      r.drawn = 1'b1; r.dst_x = x[31:0]; r.dst_y = y[31:0];
      r.dst_w = w[30:0]; r.dst_h = h[30:0];
      r.src_x = ox[14:0]; r.src_y = oy[14:0]; r.src_w = ow[11:0]; r.src_h = oh[11:0];
      r.flip = c.mirrored;
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) blit_q.push_back(clip_blit(cmd_t'({
          cmd_ch.pos_x, cmd_ch.pos_y, cmd_ch.src_off_x, cmd_ch.src_off_y,
          cmd_ch.src_size_w, cmd_ch.src_size_h, cmd_ch.scale_x, cmd_ch.scale_y,
          cmd_ch.mirrored})));
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (cmd_q.size() > 0 && !hold_send && $urandom_range(99) >= send_idle) begin
          cmd_t c;
          c = cmd_q.pop_front();
          cmd_ch.valid <= 1'b1;
          cmd_ch.pos_x <= c.pos_x; cmd_ch.pos_y <= c.pos_y;
          cmd_ch.src_off_x <= c.src_off_x; cmd_ch.src_off_y <= c.src_off_y;
          cmd_ch.src_size_w <= c.src_size_w; cmd_ch.src_size_h <= c.src_size_h;
          cmd_ch.scale_x <= c.scale_x; cmd_ch.scale_y <= c.scale_y;
          cmd_ch.mirrored <= c.mirrored;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle);
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (res_ch.valid && res_ch.ready) begin
        blit_t got, want;
        got = {res_ch.drawn, res_ch.dst_x, res_ch.dst_y, res_ch.dst_w, res_ch.dst_h,
               res_ch.out_src_x, res_ch.out_src_y, res_ch.out_src_w, res_ch.out_src_h,
               res_ch.flip};
        if (blit_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          want = blit_q.pop_front();
          if (got.drawn !== want.drawn || got.dst_x !== want.dst_x ||
              got.dst_y !== want.dst_y || got.dst_w !== want.dst_w ||
              got.dst_h !== want.dst_h || got.src_x !== want.src_x ||
              got.src_y !== want.src_y || got.src_w !== want.src_w ||
              got.src_h !== want.src_h || got.flip !== want.flip) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            errors++;
          end
        end
      end
      if (quiet > 20000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic reg_write(sbc_pkg::reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= sbc_pkg::ADDR_W'(4 * int'(idx)); cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    case (idx)
      sbc_pkg::REG_CLIP_LEFT:    m_left  = val[13:0];
      sbc_pkg::REG_CLIP_TOP:     m_top   = val[13:0];
      sbc_pkg::REG_CLIP_WIDTH:   m_cw    = val[13:0];
      sbc_pkg::REG_CLIP_HEIGHT:  m_ch    = val[13:0];
      sbc_pkg::REG_RENDER_SCALE: m_scale = val[15:0];
      default: ;
    endcase
  endtask

  // sampled on the falling edge so the driver's updates have settled
  task automatic drain();
    while (cmd_q.size() > 0 || cmd_ch.valid || blit_q.size() > 0) @(negedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_clip(int l, int t, int cw, int chh, int sc);
    reg_write(sbc_pkg::REG_CLIP_LEFT, l);
    reg_write(sbc_pkg::REG_CLIP_TOP, t);
    reg_write(sbc_pkg::REG_CLIP_WIDTH, cw);
    reg_write(sbc_pkg::REG_CLIP_HEIGHT, chh);
    reg_write(sbc_pkg::REG_RENDER_SCALE, sc);
  endtask

  function automatic cmd_t rand_cmd();
    cmd_t        c;
    logic [127:0] rb;
    rb = {$urandom, $urandom, $urandom, $urandom};
    c = rb[$bits(cmd_t)-1:0];
    // mostly small, on-screen sprites so clipping paths are exercised
    if ($urandom_range(9) < 8) begin
      c.pos_x = 16'(int'($urandom_range(600)) - 100);
      c.pos_y = 16'(int'($urandom_range(600)) - 100);
      c.src_size_w = 12'($urandom_range(200));
      c.src_size_h = 12'($urandom_range(200));
      c.scale_x = 16'($urandom_range(12000, 1000));
      c.scale_y = 16'($urandom_range(12000, 1000));
    end
    return c;
  endfunction

  task automatic random_batch(int n);
    repeat (n) cmd_q.push_back(rand_cmd());
  endtask

  initial begin
    cmd_t c;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    send_idle = 23; recv_idle = 67;
    // directed: extremes, mirror, zero size, clip off
    c = '0; cmd_q.push_back(c);
    c = '1; c.pos_x = 16'sh7fff; c.pos_y = 16'sh7fff; cmd_q.push_back(c);
    c = '1; c.pos_x = -16'sd32768; c.pos_y = -16'sd32768; cmd_q.push_back(c);
    c = '1; c.mirrored = 1'b0; cmd_q.push_back(c);
    drain();
    set_clip(100, 50, 200, 150, 4096);
    for (int i = 0; i < 10; i++) begin
      c = '0;
      c.pos_x = 16'(60 + 20 * i); c.pos_y = 16'(30 + 25 * i);
      c.src_off_x = 14'(10 * i); c.src_off_y = 14'(16383 - i);
      c.src_size_w = 12'd64; c.src_size_h = 12'd48; c.scale_x = 16'(4096 + 800 * i);
      c.scale_y = 16'd4096; c.mirrored = i[0];
      cmd_q.push_back(c);
    end
    c = '0; c.pos_x = 16'sd1000; c.src_size_w = 12'd10; c.src_size_h = 12'd10;
    c.scale_x = 16'd4096; c.scale_y = 16'd4096; cmd_q.push_back(c);   // outside right
    c.pos_x = 16'sd120; c.pos_y = 16'sd60; c.scale_x = 16'd1;
    cmd_q.push_back(c);                                                // degenerate width
    random_batch(250);
    drain();
    // downscaled render with inset
    set_clip(16383, 16383, 16383, 16383, 2048);
    random_batch(20);
    drain();
    set_clip(0, 0, 300, 300, 1);
    send_idle = 67; recv_idle = 23;
    random_batch(200);
    // part way through, hold the sender until every result is back
    repeat (100) @(posedge clk);
    hold_send = 1'b1;
    while (cmd_ch.valid || blit_q.size() > 0) @(negedge clk);
    hold_send = 1'b0;
    drain();
    set_clip(20, 40, 400, 350, 65535);
    send_idle = 0; recv_idle = 0;
    random_batch(150);
    drain();
    set_clip(0, 0, 0, 5, 3000);
    random_batch(150);
    drain();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/sbc_pkg.sv
hw/rtl/sbc_in_if.sv
hw/rtl/sbc_out_if.sv
hw/rtl/sbc_div.sv
hw/rtl/sbc_axis.sv
hw/rtl/sbc_regs.sv
hw/rtl/sprite_blit_clipper.sv
bench/tb_sprite_blit_clipper.sv
